@@ src/glyph_to_framebuffer_writer_assert.svh @@
// Assertion macros shared by the console renderer RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef GLYPH_TO_FRAMEBUFFER_WRITER_ASSERT_SVH
`define GLYPH_TO_FRAMEBUFFER_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTFW_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gtfw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GTFW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gtfw assertion failed");

`endif

@@ src/gtfw_pkg.sv @@
// Shared types, constants and the font table of the text console renderer.
// No dependencies; used by gtfw_row_mul and glyph_to_framebuffer_writer.
`timescale 1ns / 1ps

package gtfw_pkg;

   // Field widths.
   localparam int ADDR_W    = 32;
   localparam int ROW_W     = 32;
   localparam int COL_W     = 13;
   localparam int DIM_W     = 12;
   localparam int PITCH_W   = 14;
   localparam int CHAR_W    = 8;
   localparam int BIT_W     = 3;
   localparam int CELL_PIX  = 64;
   localparam int PIX_CNT_W = 6;
   localparam int MUL_CNT_W = 4;

   // Cell geometry.
   localparam int GLYPH_SIZE   = 8;
   localparam int LINE_ADVANCE = 9;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [PITCH_W-1:0]  pitch_type;
   typedef logic [CELL_PIX-1:0] glyph_type;

   // Configuration register indexes.
   localparam logic [7:0] REG_FRAME_BASE    = 8'd0;
   localparam logic [7:0] REG_SCREEN_WIDTH  = 8'd1;
   localparam logic [7:0] REG_SCREEN_HEIGHT = 8'd2;
   localparam logic [7:0] REG_ROW_PITCH     = 8'd3;

   // Character codes of interest.
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [5:0]        DIGIT_GLYPH  = 6'd26;

   // Font ROM: row 0 sits in the low byte, and bit k of each byte is column k,
   // so pixel n of the cell (row-major) is bit n of the word.
   function automatic glyph_type glyph_bits(input logic [5:0] idx);
      glyph_type w;
      unique case (idx)
         6'd0:  w = 64'h0033_333F_3333_1E0C;
         6'd1:  w = 64'h003F_6666_3E66_663F;
         6'd2:  w = 64'h003C_6603_0303_663C;
         6'd3:  w = 64'h001F_3666_6666_361F;
         6'd4:  w = 64'h007F_4616_1E16_467F;
         6'd5:  w = 64'h000F_0616_1E16_467F;
         6'd6:  w = 64'h007C_6673_0303_663C;
         6'd7:  w = 64'h0033_3333_3F33_3333;
         6'd8:  w = 64'h001E_0C0C_0C0C_0C1E;
         6'd9:  w = 64'h001E_3333_3030_3078;
         6'd10: w = 64'h0067_6636_1E36_6667;
         6'd11: w = 64'h007F_6646_0606_060F;
         6'd12: w = 64'h0063_636B_7F7F_7763;
         6'd13: w = 64'h0063_6373_7B6F_6763;
         6'd14: w = 64'h001C_3663_6363_361C;
         6'd15: w = 64'h000F_0606_3E66_663F;
         6'd16: w = 64'h0038_1E3B_3333_331E;
         6'd17: w = 64'h0067_6636_3E66_663F;
         6'd18: w = 64'h001E_3338_0E07_331E;
         6'd19: w = 64'h001E_0C0C_0C0C_2D3F;
         6'd20: w = 64'h003F_3333_3333_3333;
         6'd21: w = 64'h000C_1E33_3333_3333;
         6'd22: w = 64'h0063_777F_6B63_6363;
         6'd23: w = 64'h0063_361C_1C36_6363;
         6'd24: w = 64'h001E_0C0C_1E33_3333;
         6'd25: w = 64'h007F_664C_1831_637F;
         6'd26: w = 64'h003E_676F_7B73_633E;
         6'd27: w = 64'h003F_0C0C_0C0C_0E0C;
         6'd28: w = 64'h003F_3306_1C30_331E;
         6'd29: w = 64'h001E_3330_1C30_331E;
         6'd30: w = 64'h0078_307F_3336_3C38;
         6'd31: w = 64'h001E_3330_301F_033F;
         6'd32: w = 64'h001E_3333_1F03_061C;
         6'd33: w = 64'h000C_0C0C_1830_333F;
         6'd34: w = 64'h001E_3333_1E33_331E;
         6'd35: w = 64'h000E_1830_3E33_331E;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

@@ src/gtfw_row_mul.sv @@
// Shift-and-add unit that forms base + row * pitch modulo 2^32.
// Depends on gtfw_pkg; one pitch bit is retired per cycle.
`timescale 1ns / 1ps

module gtfw_row_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  gtfw_pkg::addr_type   base,
   input  gtfw_pkg::row_type    row,
   input  gtfw_pkg::pitch_type  pitch,
   output logic                 done,
   output gtfw_pkg::addr_type   product
);
   import gtfw_pkg::*;

   localparam logic [MUL_CNT_W-1:0] LAST_STEP = MUL_CNT_W'(PITCH_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] step_ff, step_in;
   addr_type             acc_ff, acc_in;
   addr_type             mcand_ff, mcand_in;
   pitch_type            mplier_ff, mplier_in;

   // Each step adds the shifted row when the low multiplier bit is set.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         step_in   = '0;
         acc_in    = base;
         mcand_in  = row;
         mplier_in = pitch;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[ADDR_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[PITCH_W-1:1]};
         step_in   = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ src/glyph_to_framebuffer_writer.sv @@
// Top level of the 8x8 text console renderer for a 1 bpp framebuffer.
// Depends on gtfw_pkg, gtfw_row_mul and glyph_to_framebuffer_writer_assert.svh.
`timescale 1ns / 1ps
`include "glyph_to_framebuffer_writer_assert.svh"

// Usage:
// The req channel takes one character code per item. A newline moves the
// cursor and produces nothing; it is absorbed in the cycle it is accepted.
// Any other code produces 64 pixel writes on the rsp channel, row by row,
// with last_pixel set on the 64th. Letters and digits draw a font glyph;
// every other code draws a blank cell.
// After a drawn item is accepted, the COLWRAP and ROWWRAP states check the
// cursor wrap. The shift-and-add row multiplier then retires one pitch bit
// per cycle and hands its product over as the row start address. The 64
// writes follow at one per cycle while rsp does not stall. req_stall stays
// high until the last write of the cell has entered the output register;
// that write may still wait there while the next item is taken. A stall on
// rsp holds the current write and pauses the cell walk. The csr channel is
// always ready. The user must write registers only while idle; the block
// itself does not enforce this. Reset restores the register defaults and
// puts the cursor at (1, 1).
module glyph_to_framebuffer_writer (
   input  logic                       clock,
   input  logic                       reset,
   // Character input
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_char_code,
   // Pixel write output
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output gtfw_pkg::addr_type         rsp_byte_address,
   output logic [2:0]                 rsp_bit_index,
   output logic                       rsp_pixel_on,
   output logic                       rsp_last_pixel,
   // Register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_index,
   input  logic [31:0]                csr_wdata
);
   import gtfw_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_COLWRAP = 3'd1;
   localparam logic [2:0] S_ROWWRAP = 3'd2;
   localparam logic [2:0] S_MULT    = 3'd3;
   localparam logic [2:0] S_EMIT    = 3'd4;

   localparam logic [PIX_CNT_W-1:0] LAST_PIX = PIX_CNT_W'(CELL_PIX - 1);

   logic [2:0]           state_ff, state_in;
   addr_type             frame_base_ff, frame_base_in;
   logic [DIM_W-1:0]     screen_width_ff, screen_width_in;
   logic [DIM_W-1:0]     screen_height_ff, screen_height_in;
   pitch_type            row_pitch_ff, row_pitch_in;
   logic [COL_W-1:0]     cursor_col_ff, cursor_col_in;
   row_type              cursor_row_ff, cursor_row_in;
   glyph_type            glyph_sr_ff, glyph_sr_in;
   addr_type             row_addr_ff, row_addr_in;
   logic [PIX_CNT_W-1:0] pix_cnt_ff, pix_cnt_in;
   logic                 out_valid_ff, out_valid_in;
   addr_type             out_addr_ff, out_addr_in;
   logic [BIT_W-1:0]     out_bit_ff, out_bit_in;
   logic                 out_pixel_ff, out_pixel_in;
   logic                 out_last_ff, out_last_in;

   logic                 req_take;
   logic                 out_load;
   logic                 glyph_blank;
   logic [5:0]           glyph_idx;
   logic                 col_wrap;
   logic                 row_wrap;
   logic [COL_W:0]       pix_x;
   logic                 mul_start;
   logic                 mul_done;
   addr_type             mul_product;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_load  = !out_valid_ff || !rsp_stall;

   // Character decode: fold lower case, map letters and digits to glyphs.
   always_comb begin
      glyph_blank = 1'b1;
      glyph_idx   = '0;
      if (req_char_code >= CHAR_LOWER_A && req_char_code <= CHAR_LOWER_Z) begin
         glyph_blank = 1'b0;
         glyph_idx   = 6'(req_char_code - CHAR_LOWER_A);
      end else if (req_char_code >= CHAR_UPPER_A && req_char_code <= CHAR_UPPER_Z) begin
         glyph_blank = 1'b0;
         glyph_idx   = 6'(req_char_code - CHAR_UPPER_A);
      end else if (req_char_code >= CHAR_ZERO && req_char_code <= CHAR_NINE) begin
         glyph_blank = 1'b0;
         glyph_idx   = 6'(req_char_code - CHAR_ZERO) + DIGIT_GLYPH;
      end
   end

   // Wrap checks, both widened so that they cannot overflow.
   assign col_wrap = ({1'b0, cursor_col_ff} + (COL_W+1)'(GLYPH_SIZE))
                     > (COL_W+1)'(screen_width_ff);
   assign row_wrap = ({1'b0, cursor_row_ff} + (ROW_W+1)'(GLYPH_SIZE))
                     > (ROW_W+1)'(screen_height_ff);

   // Pixel column of the current write.
   assign pix_x = {1'b0, cursor_col_ff} + (COL_W+1)'(pix_cnt_ff[2:0]);

   assign mul_start = (state_ff == S_ROWWRAP);

   gtfw_row_mul u_row_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .base    (frame_base_ff),
      .row     (cursor_row_in),
      .pitch   (row_pitch_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // Register file writes.
   always_comb begin
      frame_base_in    = frame_base_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      row_pitch_in     = row_pitch_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRAME_BASE:    frame_base_in    = csr_wdata;
            REG_SCREEN_WIDTH:  screen_width_in  = csr_wdata[DIM_W-1:0];
            REG_SCREEN_HEIGHT: screen_height_in = csr_wdata[DIM_W-1:0];
            REG_ROW_PITCH:     row_pitch_in     = csr_wdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: cursor wrap, row address, then the cell walk.
   always_comb begin
      state_in      = state_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      glyph_sr_in   = glyph_sr_ff;
      row_addr_in   = row_addr_ff;
      pix_cnt_in    = pix_cnt_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_addr_in   = out_addr_ff;
      out_bit_in    = out_bit_ff;
      out_pixel_in  = out_pixel_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_char_code == CHAR_NEWLINE) begin
                  cursor_col_in = COL_W'(1);
                  cursor_row_in = cursor_row_ff + ROW_W'(LINE_ADVANCE);
               end else begin
                  glyph_sr_in = glyph_blank ? '0 : glyph_bits(glyph_idx);
                  state_in    = S_COLWRAP;
               end
            end
         end
         S_COLWRAP: begin
            if (col_wrap) begin
               cursor_col_in = COL_W'(1);
               cursor_row_in = cursor_row_ff + ROW_W'(LINE_ADVANCE);
            end
            state_in = S_ROWWRAP;
         end
         S_ROWWRAP: begin
            if (row_wrap) begin
               cursor_row_in = ROW_W'(1);
            end
            state_in = S_MULT;
         end
         S_MULT: begin
            if (mul_done) begin
               row_addr_in = mul_product;
               pix_cnt_in  = '0;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_addr_in  = row_addr_ff + ADDR_W'(pix_x[COL_W:3]);
               out_bit_in   = ~pix_x[2:0];
               out_pixel_in = glyph_sr_ff[0];
               out_last_in  = (pix_cnt_ff == LAST_PIX);
               glyph_sr_in  = {1'b0, glyph_sr_ff[CELL_PIX-1:1]};
               pix_cnt_in   = pix_cnt_ff + 1'b1;
               if (pix_cnt_ff[2:0] == 3'd7) begin
                  row_addr_in = row_addr_ff + ADDR_W'(row_pitch_ff);
               end
               if (pix_cnt_ff == LAST_PIX) begin
                  cursor_col_in = cursor_col_ff + COL_W'(GLYPH_SIZE);
                  state_in      = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         frame_base_ff    <= '0;
         screen_width_ff  <= DIM_W'(512);
         screen_height_ff <= DIM_W'(342);
         row_pitch_ff     <= PITCH_W'(64);
         cursor_col_ff    <= COL_W'(1);
         cursor_row_ff    <= ROW_W'(1);
         pix_cnt_ff       <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frame_base_ff    <= frame_base_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         row_pitch_ff     <= row_pitch_in;
         cursor_col_ff    <= cursor_col_in;
         cursor_row_ff    <= cursor_row_in;
         pix_cnt_ff       <= pix_cnt_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      glyph_sr_ff  <= glyph_sr_in;
      row_addr_ff  <= row_addr_in;
      out_addr_ff  <= out_addr_in;
      out_bit_ff   <= out_bit_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_bit_index    = out_bit_ff;
   assign rsp_pixel_on     = out_pixel_ff;
   assign rsp_last_pixel   = out_last_ff;

   // The multiplier finishes only while the sequencer waits for it.
   `GTFW_ASSERT_SAME(a_mul_done_in_mult, mul_done, state_ff == S_MULT)

   // After the row check the cell fits vertically or sits at the top row.
   `GTFW_ASSERT_NEXT(a_row_fits, state_ff == S_ROWWRAP,
      cursor_row_ff == ROW_W'(1) || !row_wrap)

   // A drawn character starts the wrap check in the following cycle.
   `GTFW_ASSERT_NEXT(a_draw_starts, req_take && req_char_code != CHAR_NEWLINE,
      state_ff == S_COLWRAP)

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the 8x8 text console renderer (glyph_to_framebuffer_writer).
// Needs gtfw_pkg and the RTL; holds its own cursor, register and font model to
// predict every pixel write.
`timescale 1ns / 1ps

module tb_top;
   import gtfw_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PLAN_LEN = 31;
   localparam logic [7:0] REG_BEYOND = 8'd4;

   typedef struct {
      addr_type   addr;
      logic [2:0] bit_idx;
      logic       on;
      logic       last;
   } pixel_write_type;

   typedef enum logic [0:0] {STEP_CHAR, STEP_REG} step_kind_type;

   // One row of the directed plan: a character or a register write. Where
   // pinned is set, the first pixel write of the cell is typed in by hand.
   typedef struct packed {
      step_kind_type kind;
      logic [7:0] code;
      logic [31:0] wdata;
      logic       pinned;
      addr_type   first_addr;
      logic [2:0] first_bit;
      logic       first_on;
   } plan_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   addr_type    rsp_byte_address;
   logic [2:0]  rsp_bit_index;
   logic        rsp_pixel_on;
   logic        rsp_last_pixel;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Predictor state: registers and cursor.
   addr_type    fb_base;
   logic [11:0] width_px;
   logic [11:0] height_px;
   pitch_type   pitch_bytes;
   logic [12:0] cur_x;
   row_type     cur_y;

   pixel_write_type pending_writes[$];
   bit          steady = 1'b0;
   int          error_count = 0;
   int          writes_checked = 0;
   int          chars_sent = 0;
   int          newlines_sent = 0;
   int          reg_writes = 0;
   int          cycle_count = 0;

   plan_step_type plan [PLAN_LEN] = '{
      // Register defaults after reset.
      '{STEP_CHAR, 8'h41, 32'h0, 1'b1, 32'd64, 3'd6, 1'b0},
      '{STEP_CHAR, CHAR_NEWLINE, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h7A, 32'h0, 1'b1, 32'd640, 3'd6, 1'b1},
      '{STEP_CHAR, 8'h30, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h39, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h00, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'hFF, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h80, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h20, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h40, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h5B, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h60, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h7B, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h2F, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h3A, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h6D, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      // Zero-size screen, top base, widest pitch; upper data bits ignored.
      '{STEP_REG, REG_FRAME_BASE, 32'hFFFF_FFFF, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_SCREEN_WIDTH, 32'h0000_0000, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_SCREEN_HEIGHT, 32'hFFFF_F000, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_ROW_PITCH, 32'hFFFF_FFFF, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_BEYOND, 32'h0000_0200, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h38, 32'h0, 1'b1, 32'h0000_3FFE, 3'd6, 1'b0},
      '{STEP_CHAR, CHAR_NEWLINE, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h57, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      // Largest screen, zero pitch, zero base.
      '{STEP_REG, REG_FRAME_BASE, 32'h0000_0000, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_SCREEN_WIDTH, 32'h0000_0FFF, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_SCREEN_HEIGHT, 32'h0000_0FFF, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_REG, REG_ROW_PITCH, 32'h0000_0000, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h51, 32'h0, 1'b1, 32'd1, 3'd6, 1'b0},
      '{STEP_CHAR, 8'h7F, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0},
      '{STEP_CHAR, 8'h61, 32'h0, 1'b0, 32'd0, 3'd0, 1'b0}
   };

   glyph_to_framebuffer_writer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_address (rsp_byte_address),
      .rsp_bit_index    (rsp_bit_index),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Font rows: letters A to Z, then digits 0 to 9. Bit k is column k.
   function automatic logic [7:0] glyph_row_bits(input int glyph, input int row);
      logic [7:0] rows [8];
      case (glyph)
         0:  rows = '{8'h0C, 8'h1E, 8'h33, 8'h33, 8'h3F, 8'h33, 8'h33, 8'h00};
         1:  rows = '{8'h3F, 8'h66, 8'h66, 8'h3E, 8'h66, 8'h66, 8'h3F, 8'h00};
         2:  rows = '{8'h3C, 8'h66, 8'h03, 8'h03, 8'h03, 8'h66, 8'h3C, 8'h00};
         3:  rows = '{8'h1F, 8'h36, 8'h66, 8'h66, 8'h66, 8'h36, 8'h1F, 8'h00};
         4:  rows = '{8'h7F, 8'h46, 8'h16, 8'h1E, 8'h16, 8'h46, 8'h7F, 8'h00};
         5:  rows = '{8'h7F, 8'h46, 8'h16, 8'h1E, 8'h16, 8'h06, 8'h0F, 8'h00};
         6:  rows = '{8'h3C, 8'h66, 8'h03, 8'h03, 8'h73, 8'h66, 8'h7C, 8'h00};
         7:  rows = '{8'h33, 8'h33, 8'h33, 8'h3F, 8'h33, 8'h33, 8'h33, 8'h00};
         8:  rows = '{8'h1E, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h1E, 8'h00};
         9:  rows = '{8'h78, 8'h30, 8'h30, 8'h30, 8'h33, 8'h33, 8'h1E, 8'h00};
         10: rows = '{8'h67, 8'h66, 8'h36, 8'h1E, 8'h36, 8'h66, 8'h67, 8'h00};
         11: rows = '{8'h0F, 8'h06, 8'h06, 8'h06, 8'h46, 8'h66, 8'h7F, 8'h00};
         12: rows = '{8'h63, 8'h77, 8'h7F, 8'h7F, 8'h6B, 8'h63, 8'h63, 8'h00};
         13: rows = '{8'h63, 8'h67, 8'h6F, 8'h7B, 8'h73, 8'h63, 8'h63, 8'h00};
         14: rows = '{8'h1C, 8'h36, 8'h63, 8'h63, 8'h63, 8'h36, 8'h1C, 8'h00};
         15: rows = '{8'h3F, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h06, 8'h0F, 8'h00};
         16: rows = '{8'h1E, 8'h33, 8'h33, 8'h33, 8'h3B, 8'h1E, 8'h38, 8'h00};
         17: rows = '{8'h3F, 8'h66, 8'h66, 8'h3E, 8'h36, 8'h66, 8'h67, 8'h00};
         18: rows = '{8'h1E, 8'h33, 8'h07, 8'h0E, 8'h38, 8'h33, 8'h1E, 8'h00};
         19: rows = '{8'h3F, 8'h2D, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h1E, 8'h00};
         20: rows = '{8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h3F, 8'h00};
         21: rows = '{8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h1E, 8'h0C, 8'h00};
         22: rows = '{8'h63, 8'h63, 8'h63, 8'h6B, 8'h7F, 8'h77, 8'h63, 8'h00};
         23: rows = '{8'h63, 8'h63, 8'h36, 8'h1C, 8'h1C, 8'h36, 8'h63, 8'h00};
         24: rows = '{8'h33, 8'h33, 8'h33, 8'h1E, 8'h0C, 8'h0C, 8'h1E, 8'h00};
         25: rows = '{8'h7F, 8'h63, 8'h31, 8'h18, 8'h4C, 8'h66, 8'h7F, 8'h00};
         26: rows = '{8'h3E, 8'h63, 8'h73, 8'h7B, 8'h6F, 8'h67, 8'h3E, 8'h00};
         27: rows = '{8'h0C, 8'h0E, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h3F, 8'h00};
         28: rows = '{8'h1E, 8'h33, 8'h30, 8'h1C, 8'h06, 8'h33, 8'h3F, 8'h00};
         29: rows = '{8'h1E, 8'h33, 8'h30, 8'h1C, 8'h30, 8'h33, 8'h1E, 8'h00};
         30: rows = '{8'h38, 8'h3C, 8'h36, 8'h33, 8'h7F, 8'h30, 8'h78, 8'h00};
         31: rows = '{8'h3F, 8'h03, 8'h1F, 8'h30, 8'h30, 8'h33, 8'h1E, 8'h00};
         32: rows = '{8'h1C, 8'h06, 8'h03, 8'h1F, 8'h33, 8'h33, 8'h1E, 8'h00};
         33: rows = '{8'h3F, 8'h33, 8'h30, 8'h18, 8'h0C, 8'h0C, 8'h0C, 8'h00};
         34: rows = '{8'h1E, 8'h33, 8'h33, 8'h1E, 8'h33, 8'h33, 8'h1E, 8'h00};
         default: rows = '{8'h1E, 8'h33, 8'h33, 8'h3E, 8'h30, 8'h18, 8'h0E, 8'h00};
      endcase
      return rows[row];
   endfunction

   // Moves the cursor for one character and, unless it is a newline, queues the
   // 64 pixel writes of its cell. A pinned first write replaces the computed one.
   function automatic void draw_cell_writes(input logic [7:0] code, input logic pinned,
                                            input addr_type p_addr, input logic [2:0] p_bit,
                                            input logic p_on);
      logic [7:0]   c;
      logic         blank;
      int           glyph;
      logic [7:0]   bits;
      logic [31:0]  x;
      logic [31:0]  y;
      pixel_write_type w;
      c = code;
      blank = 1'b1;
      glyph = 0;
      if (c == CHAR_NEWLINE) begin
         cur_x = 13'd1;
         cur_y = cur_y + LINE_ADVANCE;
         return;
      end
      // Fold lower case onto upper case, then pick the glyph.
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
         c = c - (CHAR_LOWER_A - CHAR_UPPER_A);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         glyph = int'(c - CHAR_UPPER_A);
         blank = 1'b0;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         glyph = int'(c - CHAR_ZERO) + int'(DIGIT_GLYPH);
         blank = 1'b0;
      end
      // Line wrap first, then wrap to the top of the screen.
      if (int'(cur_x) + GLYPH_SIZE > int'(width_px)) begin
         cur_x = 13'd1;
         cur_y = cur_y + LINE_ADVANCE;
      end
      if ({1'b0, cur_y} + 33'd8 > {21'b0, height_px})
         cur_y = 32'd1;
      for (int r = 0; r < GLYPH_SIZE; r++) begin
         y = cur_y + r;
         bits = blank ? 8'h00 : glyph_row_bits(glyph, r);
         for (int k = 0; k < GLYPH_SIZE; k++) begin
            x = 32'(cur_x) + k;
            w.addr = fb_base + y * 32'(pitch_bytes) + (x >> 3);
            w.bit_idx = 3'd7 - x[2:0];
            w.on = bits[k];
            w.last = (r == GLYPH_SIZE - 1) && (k == GLYPH_SIZE - 1);
            if (pinned && r == 0 && k == 0) begin
               w.addr = p_addr;
               w.bit_idx = p_bit;
               w.on = p_on;
            end
            pending_writes.push_back(w);
         end
      end
      cur_x = cur_x + 13'(GLYPH_SIZE);
   endfunction

   // Random idling on both channels, switched off during the steady phase.
   function automatic bit idle_roll();
      return !steady && ($urandom_range(0, 99) < 34);
   endfunction

   // Offers one character, waits for acceptance and predicts its writes.
   // Returns at a falling edge with valid still high.
   task automatic push_char(input logic [7:0] code, input logic pinned = 1'b0,
                            input addr_type p_addr = '0, input logic [2:0] p_bit = '0,
                            input logic p_on = 1'b0);
      while (idle_roll()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      draw_cell_writes(code, pinned, p_addr, p_bit, p_on);
      chars_sent++;
      if (code == CHAR_NEWLINE)
         newlines_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every expected write has come and the block
   // has had time to settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write; unknown indexes leave the model untouched.
   task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FRAME_BASE:    fb_base = data;
         REG_SCREEN_WIDTH:  width_px = data[11:0];
         REG_SCREEN_HEIGHT: height_px = data[11:0];
         REG_ROW_PITCH:     pitch_bytes = data[PITCH_W-1:0];
         default:           ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver stalls.
   always @(negedge clock) begin
      rsp_stall <= idle_roll();
   end

   // Compare each accepted pixel write with the oldest expected one.
   always @(posedge clock) begin : check_writes
      pixel_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected pixel write: byte_address %h", rsp_byte_address);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (rsp_byte_address !== want.addr) begin
               $error("byte_address: expected %h, got %h", want.addr, rsp_byte_address);
               error_count++;
            end
            if (rsp_bit_index !== want.bit_idx) begin
               $error("bit_index: expected %0d, got %0d", want.bit_idx, rsp_bit_index);
               error_count++;
            end
            if (rsp_pixel_on !== want.on) begin
               $error("pixel_on: expected %0d, got %0d", want.on, rsp_pixel_on);
               error_count++;
            end
            if (rsp_last_pixel !== want.last) begin
               $error("last_pixel: expected %0d, got %0d", want.last, rsp_last_pixel);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d writes outstanding.",
                  cycle_count, pending_writes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      int          pick;
      logic [7:0]  code;
      logic [11:0] w_px;
      logic [11:0] h_px;
      fb_base = '0;
      width_px = 12'd512;
      height_px = 12'd342;
      pitch_bytes = 14'd64;
      cur_x = 13'd1;
      cur_y = 32'd1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed plan.
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].kind == STEP_REG) begin
            wait_idle();
            write_reg(plan[i].code, plan[i].wdata);
         end else begin
            push_char(plan[i].code, plan[i].pinned, plan[i].first_addr,
                      plan[i].first_bit, plan[i].first_on);
         end
      end

      // Random phases, each with its own screen setup.
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         steady = (phase == 2);
         case (phase % 3)
            0: begin
               w_px = 12'($urandom_range(8, 48));
               h_px = 12'($urandom_range(8, 48));
            end
            1: begin
               w_px = 12'($urandom_range(0, 4095));
               h_px = 12'($urandom_range(0, 4095));
            end
            default: begin
               w_px = 12'($urandom_range(0, 15));
               h_px = 12'($urandom_range(0, 20));
            end
         endcase
         write_reg(REG_FRAME_BASE, (phase == 3) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                                : $urandom);
         write_reg(REG_SCREEN_WIDTH, ($urandom & 32'hFFFF_F000) | 32'(w_px));
         write_reg(REG_SCREEN_HEIGHT, ($urandom & 32'hFFFF_F000) | 32'(h_px));
         write_reg(REG_ROW_PITCH, ($urandom & 32'hFFFF_C000) | $urandom_range(0, 16383));
         if (phase % 2 == 1)
            write_reg(8'($urandom_range(4, 255)), $urandom);
         repeat (18) begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
               code = 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
            else if (pick < 48)
               code = 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
            else if (pick < 64)
               code = 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
            else if (pick < 76)
               code = CHAR_NEWLINE;
            else
               code = 8'($urandom_range(0, 255));
            push_char(code);
         end
      end

      wait_idle();
      $display("Sent %0d characters (%0d newlines) over %0d register writes.",
               chars_sent, newlines_sent, reg_writes);
      $display("Checked %0d pixel writes, %0d mismatches.", writes_checked, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
